### src/kls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_pkg
// Shared types and constants for the keyframe interpolation sampler.
// ---------------------------------------------------------------------------
package kls_pkg;
	localparam int MAX_KEYS = 16;
	localparam int NCOMP = 9;
	localparam int KIDX_W = $clog2(MAX_KEYS);
	localparam int KCNT_W = 5;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CLIP  = 2'd0,
		REG_SPEED = 2'd1,
		REG_LOOP  = 2'd2,
		REG_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SEARCH,
		ST_READ,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         key_index;
		logic [31:0]        time_now;
		logic [NCOMP*32-1:0] comp;
	} in_beat_t;

	typedef struct packed {
		logic [NCOMP*32-1:0] comp;
		logic                still_playing;
		logic                key_found;
	} out_beat_t;

	typedef struct packed {
		logic        start;
		logic [16:0] frac;
	} lane_ctl_t;
endpackage

### src/kls_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_if
// Valid/ready channel carrying one beat of a packed payload.
// ---------------------------------------------------------------------------
interface kls_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/kls_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/kls_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_lane
// One component lane: holds the key values and interpolates a + (b-a)*f.
// ---------------------------------------------------------------------------
module kls_lane
	import kls_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [KIDX_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic [KIDX_W-1:0] raddr,
	input  logic              rd_a,
	input  logic              rd_b,
	input  lane_ctl_t         ctl,
	output logic [31:0]       result
);
	logic [31:0] rdata;
	logic [31:0] a_q;
	logic [32:0] diff_s1;
	logic [49:0] prod_s2;

	kls_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_a) begin
			a_q <= rdata;
		end
		if (rd_b) begin
			diff_s1 <= 33'($signed({rdata[31], rdata}) - $signed({a_q[31], a_q}));
		end
		if (ctl.start) begin
			prod_s2 <= 50'($signed(diff_s1) * $signed({1'b0, ctl.frac}));
			result  <= 32'($signed(a_q) + $signed(prod_s2[49:16]));
		end
	end
endmodule

### src/kls_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kls_div
// Radix-2 restoring divider: floor((num << 16) / den), 17-bit quotient.
// ---------------------------------------------------------------------------
module kls_div
	import kls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quot
);
	logic [32:0] rem_q;
	logic [15:0] lo_q;
	logic [31:0] den_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q, lo_q[15]} - {2'b0, den_q};
	assign quot  = quot_q;
	assign done  = busy_q && (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd17;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// dividend is num followed by 16 zero bits; 17 quotient bits remain
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b0, num[31:1]};
			lo_q   <= {num[0], 15'd0};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q && cnt_q != 5'd0) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
			end else begin
				rem_q <= {rem_q[31:0], lo_q[15]};
			end
			lo_q   <= {lo_q[14:0], 1'b0};
			quot_q <= {quot_q[15:0], ~trial[33]};
		end
	end
endmodule

### src/keyframe_lerp_sampler_unit.sv
`timescale 1ns / 1ps
// Load, start, stop and a tick while stopped are taken without leaving idle; a tick that
// hits scales the time, searches the key times one by one, then reads three values,
// divides, and multiplies and sums in nine lanes; a miss goes from search to output.
// One item in flight at a time; the output register frees on acceptance.
// Reset (arst_n low) stops playback, clears the start stamp, clip length and loop flag,
// sets speed to 256 and key count to 1; keyframe storage is undefined until loaded.
// ---------------------------------------------------------------------------
// keyframe_lerp_sampler_unit
// Keyframe store with interval search and nine-lane linear interpolation.
// ---------------------------------------------------------------------------
module keyframe_lerp_sampler_unit
	import kls_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	kls_if.sink          in_ch,
	kls_if.source        out_ch,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	in_beat_t    ib;
	out_beat_t   ob_q;
	state_t      st_q, st_d;
	logic [31:0] clip_q;
	logic [15:0] speed_q;
	logic        loop_q;
	logic [4:0]  count_q;
	logic        playing_q;
	logic [31:0] stamp_q;
	logic [31:0] sc_q;
	logic [47:0] prod_in;
	logic [31:0] sc_in;
	logic        out_v_q;
	logic [4:0]  j_q;
	logic [4:0]  n_lim;
	logic [31:0] tprev_q;
	logic [31:0] tk_rd;
	logic [32:0] elapsed;
	logic [31:0] tp_f_q, tk_f_q;
	logic        found_q;
	logic [KIDX_W-1:0] jf_q;
	logic        rd_phase_q;
	logic [1:0]  sub_q;
	logic [KIDX_W-1:0] raddr;
	logic        div_start, div_done;
	logic [16:0] div_q;
	logic [16:0] frac_q;
	lane_ctl_t   lctl;
	logic        accept, load_we;
	logic [31:0] lane_res [NCOMP];
	logic        rd_a, rd_b;

	assign ib          = in_ch.data;
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE) && !out_v_q;
	assign load_we     = accept && (op_t'(ib.op) == OP_LOAD);
	assign n_lim       = (count_q > 5'(MAX_KEYS)) ? 5'(MAX_KEYS) : count_q;
	assign elapsed     = {1'b0, sc_q} - {1'b0, stamp_q};
	assign prod_in     = 48'(ib.time_now) * 48'(speed_q);
	assign sc_in       = (prod_in[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod_in[39:8];
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = ob_q;

	kls_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
		.clk(clk), .we(load_we), .waddr(ib.key_index[KIDX_W-1:0]),
		.wdata(ib.time_now), .raddr(raddr), .rdata(tk_rd)
	);

	always_comb begin
		raddr = j_q[KIDX_W-1:0];
		rd_a = 1'b0;
		rd_b = 1'b0;
		if (st_q == ST_READ) begin
			raddr = (sub_q == 2'd0) ? jf_q - KIDX_W'(j_q != 5'd0) : jf_q;
			rd_a  = (sub_q == 2'd1);
			rd_b  = (sub_q == 2'd2);
		end
	end

	assign div_start = (st_q == ST_READ) && (sub_q == 2'd2);
	assign lctl.start = (st_q == ST_MUL) || (st_q == ST_SUM);
	assign lctl.frac  = frac_q;

	kls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(elapsed[31:0] - tp_f_q), .den(tk_f_q - tp_f_q),
		.done(div_done), .quot(div_q)
	);

	for (genvar c = 0; c < NCOMP; c++) begin : g_lane
		kls_lane u_lane (
			.clk(clk), .we(load_we), .waddr(ib.key_index[KIDX_W-1:0]),
			.wdata(ib.comp[c*32 +: 32]), .raddr(raddr),
			.rd_a(rd_a), .rd_b(rd_b), .ctl(lctl), .result(lane_res[c])
		);
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (accept && op_t'(ib.op) == OP_TICK && playing_q) st_d = ST_SCALE;
			ST_SCALE:  st_d = ST_SEARCH;
			ST_SEARCH: begin
				if (found_q) begin
					st_d = ST_READ;
				end else if (j_q >= n_lim && !rd_phase_q) begin
					st_d = ST_OUT;
				end
			end
			ST_READ:   if (sub_q == 2'd2) st_d = ST_DIV;
			ST_DIV:    if (div_done) st_d = ST_MUL;
			ST_MUL:    st_d = ST_SUM;
			ST_SUM:    st_d = ST_OUT;
			ST_OUT:    st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			clip_q    <= '0;
			speed_q   <= 16'd256;
			loop_q    <= 1'b0;
			count_q   <= 5'd1;
			playing_q <= 1'b0;
			stamp_q   <= '0;
			out_v_q   <= 1'b0;
			j_q       <= '0;
			found_q   <= 1'b0;
			rd_phase_q <= 1'b0;
			sub_q     <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_CLIP:  clip_q  <= cfg_data;
					REG_SPEED: speed_q <= cfg_data[15:0];
					REG_LOOP:  loop_q  <= cfg_data[0];
					REG_COUNT: count_q <= cfg_data[4:0];
					default:   ;
				endcase
			end
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (accept) begin
				if (op_t'(ib.op) == OP_STOP) begin
					playing_q <= 1'b0;
				end
				if (op_t'(ib.op) == OP_START) begin
					playing_q <= 1'b1;
					stamp_q   <= sc_in;
				end
			end
			case (st_q)
				ST_SCALE: begin
					j_q <= '0;
					found_q <= 1'b0;
					rd_phase_q <= 1'b0;
					sub_q <= '0;
				end
				ST_SEARCH: begin
					if (!found_q) begin
						if (!rd_phase_q) begin
							if (j_q < n_lim) rd_phase_q <= 1'b1;
						end else begin
							rd_phase_q <= 1'b0;
							if (!elapsed[32] && elapsed[31:0] >= (j_q == 5'd0 ? tk_rd : tprev_q)
									&& tk_rd >= elapsed[31:0]) begin
								found_q <= 1'b1;
								jf_q    <= j_q[KIDX_W-1:0];
								tp_f_q  <= (j_q == 5'd0) ? tk_rd : tprev_q;
								tk_f_q  <= tk_rd;
							end else begin
								tprev_q <= tk_rd;
								j_q     <= j_q + 5'd1;
							end
						end
					end
				end
				ST_READ: sub_q <= sub_q + 2'd1;
				ST_DIV: if (div_done) frac_q <= (tk_f_q == tp_f_q) ? 17'd0 : div_q;
				ST_OUT: begin
					out_v_q <= 1'b1;
					if ({1'b0, stamp_q} + {1'b0, clip_q} < {1'b0, sc_q}) begin
						if (loop_q) stamp_q <= sc_q;
						else playing_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sc_q <= sc_in;
		end
		if (st_q == ST_OUT) begin
			for (int c = 0; c < NCOMP; c++) begin
				ob_q.comp[c*32 +: 32] <= found_q ? lane_res[c] : 32'd0;
			end
			ob_q.key_found <= found_q;
			ob_q.still_playing <= !({1'b0, stamp_q} + {1'b0, clip_q} < {1'b0, sc_q})
				|| loop_q;
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q && $stable(ob_q))
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !in_ch.ready)
		else $error("input taken while busy");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == ST_DIV)
		else $error("divider finished outside divide phase");
`endif
endmodule
